>>> rtl/swg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SwiGLU backward package
// Shared widths, the sigmoid table and the elaboration-time routines that
// build it for the SwiGLU backward gradient pipeline.
// ----------------------------------------------------------------------------
package swg_pkg;

  // Number format of the data words.
  localparam int DATA_WIDTH      = 16;
  localparam int FRAC_BITS       = 12;

  // Sigmoid table geometry: one more point than segments.
  localparam int SIG_TABLE_DEPTH = 256;
  localparam int IDX_W           = $clog2(SIG_TABLE_DEPTH);
  localparam int SEG_BITS        = DATA_WIDTH - IDX_W;
  localparam int ROM_AW          = $clog2(SIG_TABLE_DEPTH + 1);
  localparam int SIG_W           = 16;
  localparam logic [SIG_W-1:0] SIG_HALF = SIG_W'(2 ** (SIG_W - 1));

  // Interpolation widths.
  localparam int DIFF_W          = SIG_W + 1;
  localparam int DR_W            = DIFF_W + SEG_BITS + 1;
  localparam int SRAW_W          = DR_W - SEG_BITS;

  // Datapath widths.
  localparam int PROD_W          = 2 * DATA_WIDTH;
  localparam int PQ_W            = PROD_W - FRAC_BITS;
  localparam int SQ_W            = 2 * SIG_W - 1;
  localparam int XSQ_W           = DATA_WIDTH + SQ_W + 1;
  localparam int DSH             = FRAC_BITS + SIG_W;
  localparam int D_W             = XSQ_W - DSH;
  localparam int GXP_W           = PQ_W + D_W;
  localparam int GGP_W           = PQ_W + SIG_W + 1;
  localparam int GX_W            = GXP_W - SIG_W;
  localparam int GG_W            = GGP_W - SIG_W;

  // Constants of the table construction, all in Q32.
  localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;
  localparam logic [63:0] EXP_NEG1_Q32 = 64'd1580030169;

  typedef logic [SIG_TABLE_DEPTH:0][SIG_W-1:0] sig_rom_t;

  // Restoring long division, used only while the table is elaborated.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // e^-a in Q32 for a raw Q(FRAC_BITS) magnitude: Taylor series on the
  // fraction, repeated multiplies by e^-1 for the integer part.
  function automatic logic [63:0] exp_neg(input logic [63:0] a);
    logic [63:0] n;
    logic [63:0] f;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] term;
    logic [63:0] e;
    n    = a >> FRAC_BITS;
    f    = (a & ((64'd1 << FRAC_BITS) - 64'd1)) << (32 - FRAC_BITS);
    pos  = ONE_Q32;
    neg  = '0;
    term = ONE_Q32;
    for (int j = 1; j <= 20; j++) begin
      term = udiv64((term * f) >> 32, 64'(j));
      if ((j & 1) != 0) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    e = pos - neg;
    for (int j = 0; j < 48; j++) begin
      if (64'(j) < n) begin
        e = (e * EXP_NEG1_Q32 + 64'h8000_0000) >> 32;
      end
    end
    if (n >= 64'd48) begin
      e = '0;
    end
    return e;
  endfunction

  // Sigmoid points in unsigned Q0.16, evenly spaced over the input range.
  function automatic sig_rom_t build_sig_rom();
    sig_rom_t    rom;
    int          k;
    logic [63:0] mag;
    logic [63:0] den;
    logic [63:0] sp;
    logic [63:0] v;
    for (int i = 0; i <= SIG_TABLE_DEPTH; i++) begin
      k   = i - SIG_TABLE_DEPTH / 2;
      mag = (k < 0) ? 64'(-k) : 64'(k);
      den = ONE_Q32 + exp_neg(mag << SEG_BITS);
      sp  = udiv64((64'd1 << 48) + (den >> 1), den);
      v   = (k < 0) ? (64'd65536 - sp) : sp;
      if (v > 64'd65535) begin
        v = 64'd65535;
      end
      rom[i] = v[SIG_W-1:0];
    end
    return rom;
  endfunction

  localparam sig_rom_t SIG_ROM = build_sig_rom();

endpackage

>>> rtl/swg_sigmoid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sigmoid lookup
// Two-stage pipelined sigmoid: table read and slope multiply, then the
// rounded interpolation add and clamp. Output is unsigned Q0.16.
// ----------------------------------------------------------------------------
module swg_sigmoid (
  input  logic                                   clk_i,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0]  act_i,
  output logic        [swg_pkg::SIG_W-1:0]       sig_o
);

  logic [swg_pkg::DATA_WIDTH-1:0]      u;
  logic [swg_pkg::IDX_W-1:0]           idx;
  logic [swg_pkg::SEG_BITS-1:0]        frac;
  logic [swg_pkg::ROM_AW-1:0]          addr_lo;
  logic [swg_pkg::ROM_AW-1:0]          addr_hi;
  logic [swg_pkg::SIG_W-1:0]           t_lo;
  logic [swg_pkg::SIG_W-1:0]           t_hi;
  logic signed [swg_pkg::DIFF_W-1:0]   diff;
  logic signed [swg_pkg::DR_W-1:0]     dr_d;
  logic signed [swg_pkg::DR_W-1:0]     dr_q;
  logic [swg_pkg::SIG_W-1:0]           base_d;
  logic [swg_pkg::SIG_W-1:0]           base_q;
  logic signed [swg_pkg::DR_W-1:0]     dr_rnd;
  logic signed [swg_pkg::SRAW_W-1:0]   s_raw;
  logic [swg_pkg::SIG_W-1:0]           sig_d;
  logic [swg_pkg::SIG_W-1:0]           sig_q;

  // Offset the signed input to a table position and a segment fraction.
  assign u       = {~act_i[swg_pkg::DATA_WIDTH-1], act_i[swg_pkg::DATA_WIDTH-2:0]};
  assign idx     = u[swg_pkg::DATA_WIDTH-1:swg_pkg::SEG_BITS];
  assign frac    = u[swg_pkg::SEG_BITS-1:0];
  assign addr_lo = {1'b0, idx};
  assign addr_hi = {1'b0, idx} + swg_pkg::ROM_AW'(1);

  // Read both segment ends and scale the slope by the fraction.
  always_comb begin
    t_lo   = swg_pkg::SIG_ROM[addr_lo];
    t_hi   = swg_pkg::SIG_ROM[addr_hi];
    diff   = $signed({1'b0, t_hi}) - $signed({1'b0, t_lo});
    dr_d   = diff * $signed({1'b0, frac});
    base_d = t_lo;
  end

  always_ff @(posedge clk_i) begin
    dr_q   <= dr_d;
    base_q <= base_d;
  end

  // Round the slope term half up, add the base point and clamp to Q0.16.
  always_comb begin
    dr_rnd = dr_q + swg_pkg::DR_W'(2 ** (swg_pkg::SEG_BITS - 1));
    s_raw  = $signed({2'b00, base_q}) + $signed(dr_rnd[swg_pkg::DR_W-1:swg_pkg::SEG_BITS]);
    if (s_raw[swg_pkg::SRAW_W-1]) begin
      sig_d = '0;
    end else if (|s_raw[swg_pkg::SRAW_W-2:swg_pkg::SIG_W]) begin
      sig_d = '1;
    end else begin
      sig_d = s_raw[swg_pkg::SIG_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    sig_q <= sig_d;
  end

  assign sig_o = sig_q;

endmodule

>>> rtl/swiglu_backward_gradients.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SwiGLU backward gradients
// Elementwise SwiGLU backward pass in signed Q4.12 with a table-based,
// interpolated sigmoid and rounded, saturated results.
// ----------------------------------------------------------------------------
// The block takes one word per clock cycle and never pushes back: busy is
// always low, so a word is taken at every clock edge where start is high.
// Each result appears on the output ports for one cycle with done_o high,
// in the order the words came in. The pipeline has seven stages (input
// capture, then the sigmoid table read and interpolation alongside the chain
// of multipliers, each stage followed by a register).
// The sigmoid table is a constant, so there is no warm-up after reset.
module swiglu_backward_gradients (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  start,
  output logic                                  busy,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0] act_value_i,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0] gate_value_i,
  input  logic signed [swg_pkg::DATA_WIDTH-1:0] upstream_grad_i,
  output logic                                  done_o,
  output logic signed [swg_pkg::DATA_WIDTH-1:0] act_grad_o,
  output logic signed [swg_pkg::DATA_WIDTH-1:0] gate_grad_o,
  output logic                                  clipped_o
);

  typedef struct packed {
    logic                              clip;
    logic [swg_pkg::DATA_WIDTH-1:0]    val;
  } sat_t;

  localparam logic [swg_pkg::DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(swg_pkg::DATA_WIDTH-1){1'b1}}};
  localparam logic [swg_pkg::DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(swg_pkg::DATA_WIDTH-1){1'b0}}};

  // Clip a rounded result to the data width and report whether it clipped.
  function automatic sat_t sat_word(input logic [swg_pkg::GX_W-1:0] v);
    sat_t                                          res;
    logic [swg_pkg::GX_W-swg_pkg::DATA_WIDTH:0]    top;
    top      = v[swg_pkg::GX_W-1:swg_pkg::DATA_WIDTH-1];
    res.clip = !((&top) || !(|top));
    if (res.clip) begin
      res.val = v[swg_pkg::GX_W-1] ? SAT_MIN : SAT_MAX;
    end else begin
      res.val = v[swg_pkg::DATA_WIDTH-1:0];
    end
    return res;
  endfunction

  // Stage valid bits.
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q, v7_q;

  // Stage payloads.
  logic signed [swg_pkg::DATA_WIDTH-1:0] x1_q, g1_q, gy1_q;
  logic signed [swg_pkg::DATA_WIDTH-1:0] x2_q, x3_q, x4_q;
  logic signed [swg_pkg::PROD_W-1:0]     pg2_d, pg2_q, px2_d, px2_q;
  logic signed [swg_pkg::PROD_W-1:0]     pg_rnd, px_rnd;
  logic signed [swg_pkg::PQ_W-1:0]       p3_d, p3_q, q3_d, q3_q, p4_q, p5_q;
  logic        [swg_pkg::SIG_W-1:0]      s3;
  logic        [swg_pkg::SIG_W-1:0]      s4_q;
  logic        [swg_pkg::SIG_W:0]        one_minus_s;
  logic        [2*swg_pkg::SIG_W:0]      sq_full;
  logic        [swg_pkg::SQ_W-1:0]       sq4_d, sq4_q;
  logic signed [swg_pkg::GGP_W-1:0]      ggp4_d, ggp4_q, ggp5_q, ggp_rnd;
  logic signed [swg_pkg::XSQ_W-1:0]      xsq, dsum;
  logic signed [swg_pkg::D_W-1:0]        d5_d, d5_q;
  logic signed [swg_pkg::GXP_W-1:0]      gxp6_d, gxp6_q, gxp_rnd;
  logic        [swg_pkg::GX_W-1:0]       gg_ext, gx_ext;
  sat_t                                  gg6_d, gg6_q, gx7_d;
  logic        [swg_pkg::DATA_WIDTH-1:0] act_grad_q, gate_grad_q;
  logic                                  clipped_q;

  // The pipeline never stalls, so every start is taken.
  assign busy = 1'b0;

  // Valid bits travel with the words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
      v7_q <= 1'b0;
    end else begin
      v1_q <= start && !busy;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
      v6_q <= v5_q;
      v7_q <= v6_q;
    end
  end

  // Stage 1: input capture.
  always_ff @(posedge clk_i) begin
    x1_q  <= act_value_i;
    g1_q  <= gate_value_i;
    gy1_q <= upstream_grad_i;
  end

  // Sigmoid unit, result lines up with stage 3.
  swg_sigmoid u_sigmoid (
    .clk_i (clk_i),
    .act_i (x1_q),
    .sig_o (s3)
  );

  // Stage 2: upstream gradient times gate and times activation.
  always_comb begin
    pg2_d = gy1_q * g1_q;
    px2_d = gy1_q * x1_q;
  end

  always_ff @(posedge clk_i) begin
    x2_q  <= x1_q;
    pg2_q <= pg2_d;
    px2_q <= px2_d;
  end

  // Stage 3: round both products back to Q(FRAC_BITS).
  always_comb begin
    pg_rnd = pg2_q + swg_pkg::PROD_W'(2 ** (swg_pkg::FRAC_BITS - 1));
    px_rnd = px2_q + swg_pkg::PROD_W'(2 ** (swg_pkg::FRAC_BITS - 1));
    p3_d   = pg_rnd[swg_pkg::PROD_W-1:swg_pkg::FRAC_BITS];
    q3_d   = px_rnd[swg_pkg::PROD_W-1:swg_pkg::FRAC_BITS];
  end

  always_ff @(posedge clk_i) begin
    x3_q <= x2_q;
    p3_q <= p3_d;
    q3_q <= q3_d;
  end

  // Stage 4: s*(1-s) and the gate gradient product q*s.
  always_comb begin
    one_minus_s = (swg_pkg::SIG_W+1)'(2 ** swg_pkg::SIG_W) - {1'b0, s3};
    sq_full     = s3 * one_minus_s;
    sq4_d       = sq_full[swg_pkg::SQ_W-1:0];
    ggp4_d      = q3_q * $signed({1'b0, s3});
  end

  always_ff @(posedge clk_i) begin
    x4_q   <= x3_q;
    s4_q   <= s3;
    p4_q   <= p3_q;
    sq4_q  <= sq4_d;
    ggp4_q <= ggp4_d;
  end

  // Stage 5: derivative term d = s + x*s*(1-s), rounded to signed Q4.16.
  always_comb begin
    xsq  = x4_q * $signed({1'b0, sq4_q});
    dsum = xsq
         + $signed({{(swg_pkg::XSQ_W-swg_pkg::SIG_W-swg_pkg::DSH){1'b0}}, s4_q,
                    {swg_pkg::DSH{1'b0}}})
         + swg_pkg::XSQ_W'(2 ** (swg_pkg::DSH - 1));
    d5_d = dsum[swg_pkg::XSQ_W-1:swg_pkg::DSH];
  end

  always_ff @(posedge clk_i) begin
    p5_q   <= p4_q;
    d5_q   <= d5_d;
    ggp5_q <= ggp4_q;
  end

  // Stage 6: activation gradient product, gate gradient rounded and clipped.
  always_comb begin
    gxp6_d  = p5_q * d5_q;
    ggp_rnd = ggp5_q + swg_pkg::GGP_W'(2 ** (swg_pkg::SIG_W - 1));
    gg_ext  = {{(swg_pkg::GX_W-swg_pkg::GG_W){ggp_rnd[swg_pkg::GGP_W-1]}},
               ggp_rnd[swg_pkg::GGP_W-1:swg_pkg::SIG_W]};
    gg6_d   = sat_word(gg_ext);
  end

  always_ff @(posedge clk_i) begin
    gxp6_q <= gxp6_d;
    gg6_q  <= gg6_d;
  end

  // Stage 7: activation gradient rounded and clipped, output register.
  always_comb begin
    gxp_rnd = gxp6_q + swg_pkg::GXP_W'(2 ** (swg_pkg::SIG_W - 1));
    gx_ext  = gxp_rnd[swg_pkg::GXP_W-1:swg_pkg::SIG_W];
    gx7_d   = sat_word(gx_ext);
  end

  always_ff @(posedge clk_i) begin
    act_grad_q  <= gx7_d.val;
    gate_grad_q <= gg6_q.val;
    clipped_q   <= gx7_d.clip || gg6_q.clip;
  end

  assign done_o      = v7_q;
  assign act_grad_o  = act_grad_q;
  assign gate_grad_o = gate_grad_q;
  assign clipped_o   = clipped_q;

  // Every word taken gives exactly one result.
  a_latency_fwd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##7 done_o)
    else $error("result missing seven cycles after a word was taken");

  a_latency_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, 7))
    else $error("result without a word taken seven cycles before");

  // A clipped result must sit at one of the rails.
  a_clip_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && clipped_o) |->
      (act_grad_o == SAT_MAX || act_grad_o == SAT_MIN ||
       gate_grad_o == SAT_MAX || gate_grad_o == SAT_MIN))
    else $error("clip flag set with no result at a rail");

  // Sigmoid is at most one half for negative inputs and at least one half
  // otherwise.
  a_sig_half: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v4_q |-> ((x4_q[swg_pkg::DATA_WIDTH-1] && s4_q <= swg_pkg::SIG_HALF) ||
              (!x4_q[swg_pkg::DATA_WIDTH-1] && s4_q >= swg_pkg::SIG_HALF)))
    else $error("sigmoid on the wrong side of one half");

endmodule
